/* sv/dtf_pkg.sv */
// Shared types and constants of the dashboard telemetry framer.
// Holds opcodes, register indexes, frame byte positions, the configuration and
// queue item structs and the fixed-point temperature conversion. No dependencies.
`default_nettype none

package dtf_pkg;

  localparam int OPCODE_W   = 3;
  localparam int CHANNEL_W  = 2;
  localparam int SAMPLE_W   = 10;
  localparam int DOOR_W     = 4;
  localparam int SEAT_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int INDEX_W    = 3;
  localparam int SETPOINT_W = 7;
  localparam int TEMP_W     = 9;
  localparam int PCT_W      = 7;
  localparam int SPEED_W    = 16;
  localparam int WINDOW_W   = 8;
  localparam int SCALE_W    = 16;
  localparam int BAND_W     = 4;
  localparam int MODE_W     = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [SETPOINT_W-1:0] SETPOINT_MAX   = 7'd99;
  localparam logic [SETPOINT_W-1:0] SETPOINT_RESET = 7'd25;

  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 8'd125;
  localparam logic [SCALE_W-1:0]    SCALE_RESET    = 16'd2826;
  localparam logic [SETPOINT_W-1:0] AUTO_SP_RESET  = 7'd25;
  localparam logic [SETPOINT_W-1:0] AUTO_OFF_RESET = 7'd23;
  localparam logic [BAND_W-1:0]     BAND_RESET     = 4'd2;

  // temp = floor(s * 0.488758), done as (s * ceil(0.488758 * 2^32)) >> 32;
  // the rounding error stays below one step for any sample up to 12 bits
  localparam int TEMP_SHIFT  = 32;
  localparam int TEMP_PROD_W = SAMPLE_W + 31;
  localparam logic [30:0] TEMP_RECIP = 31'd2099199626;

  // speed = floor(prod / 1000) below the saturation point, via ceil(2^36 / 1000)
  localparam int SPEED_SAT_LIMIT = 65536000;
  localparam int QUOT_IN_W       = 26;
  localparam int SPEED_SHIFT     = 36;
  localparam logic [26:0] SPEED_RECIP = 27'd68719477;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 3'd0,
    OP_PULSE  = 3'd1,
    OP_SAMPLE = 3'd2,
    OP_SWITCH = 3'd3,
    OP_UP     = 3'd4,
    OP_DOWN   = 3'd5
  } opcode_e;

  typedef enum logic [CHANNEL_W-1:0] {
    CH_ENGINE  = 2'd0,
    CH_FUEL    = 2'd1,
    CH_BATTERY = 2'd2,
    CH_CABIN   = 2'd3
  } channel_e;

  typedef enum logic [2:0] {
    REG_WINDOW   = 3'd0,
    REG_SCALE    = 3'd1,
    REG_AUTO_SP  = 3'd2,
    REG_AUTO_OFF = 3'd3,
    REG_BAND     = 3'd4
  } reg_idx_e;

  typedef enum logic [INDEX_W-1:0] {
    FB_ENGINE_HI = 3'd0,
    FB_ENGINE_LO = 3'd1,
    FB_FUEL      = 3'd2,
    FB_SPEED_HI  = 3'd3,
    FB_SPEED_LO  = 3'd4,
    FB_DOOR      = 3'd5,
    FB_BELT      = 3'd6,
    FB_BATTERY   = 3'd7
  } frame_byte_e;

  typedef struct packed {
    logic [WINDOW_W-1:0]   window_ticks;
    logic [SCALE_W-1:0]    speed_scale;
    logic [SETPOINT_W-1:0] auto_setpoint;
    logic [SETPOINT_W-1:0] auto_off_temp;
    logic [BAND_W-1:0]     manual_band;
  } cfg_t;

  // Per-item queue fields; the pulse count is queued alongside them
  typedef struct packed {
    logic                  is_frame;
    logic [TEMP_W-1:0]     engine_temp;
    logic [PCT_W-1:0]      fuel_pct;
    logic [PCT_W-1:0]      batt_pct;
    logic                  door_ok;
    logic                  belt_ok;
    logic                  ac_on;
    logic [SETPOINT_W-1:0] setpoint;
  } item_info_t;

  function automatic logic [TEMP_W-1:0] temp_of(input logic [SAMPLE_W-1:0] s);
    logic [TEMP_PROD_W-1:0] p;
    p = TEMP_PROD_W'(s) * TEMP_PROD_W'(TEMP_RECIP);
    return p[TEMP_SHIFT +: TEMP_W];
  endfunction

endpackage

`default_nettype wire

/* sv/dtf_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on dtf_pkg for the field widths.
`default_nettype none

interface dtf_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtf_pkg::OPCODE_W-1:0]   opcode;
  logic [dtf_pkg::CHANNEL_W-1:0]  channel;
  logic [dtf_pkg::SAMPLE_W-1:0]   sample;
  logic [dtf_pkg::DOOR_W-1:0]     door_switches;
  logic [dtf_pkg::SEAT_W-1:0]     seat_switches;
  logic                           auto_mode;
  logic                           manual_mode;

  modport source (
    output valid, opcode, channel, sample, door_switches, seat_switches,
           auto_mode, manual_mode,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, sample, door_switches, seat_switches,
           auto_mode, manual_mode,
    output ready
  );
endinterface

interface dtf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            is_frame;
  logic [dtf_pkg::BYTE_W-1:0]      frame_byte;
  logic [dtf_pkg::INDEX_W-1:0]     byte_index;
  logic                            last;
  logic                            ac_on;
  logic [dtf_pkg::SETPOINT_W-1:0]  current_setpoint;

  modport source (
    output valid, is_frame, frame_byte, byte_index, last, ac_on, current_setpoint,
    input  ready
  );
  modport sink (
    input  valid, is_frame, frame_byte, byte_index, last, ac_on, current_setpoint,
    output ready
  );
endinterface

`default_nettype wire

/* sv/dtf_fifo.sv */
// Small register queue between the front and back ends of the framer.
// Standalone; width and depth come from the instantiating module.
`default_nettype none

module dtf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/dtf_front.sv */
// Front end: accepts items, updates counters, samples, switches and climate state,
// and queues one entry per item. Depends on dtf_pkg and dtf_in_if.
`default_nettype none

module dtf_front #(
  parameter int PULSE_BITS  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  dtf_in_if.sink                  item_i,
  input  dtf_pkg::cfg_t           cfg_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output dtf_pkg::item_info_t     push_info_o,
  output logic [PULSE_BITS-1:0]   push_pulse_o
);

  import dtf_pkg::*;

  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  // percent = floor(s * 100 / (2^SAMPLE_BITS - 1)) via a 2^32 scaled reciprocal
  localparam longint unsigned PCT_DIV   = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam longint unsigned PCT_RECIP = ((64'd1 << 32) + PCT_DIV - 64'd1) / PCT_DIV;
  localparam logic [31:0]     PCT_MUL   = 32'(PCT_RECIP * 64'd100);
  localparam int              PCT_PROD_W = SAMPLE_W + 32;
  localparam logic [PULSE_BITS-1:0] PULSE_MAX = '1;
  localparam logic [WINDOW_W-1:0]   TICK_MAX  = '1;

  function automatic logic [PCT_W-1:0] pct_of(input logic [SAMPLE_W-1:0] s);
    logic [PCT_PROD_W-1:0] p;
    p = PCT_PROD_W'(s) * PCT_PROD_W'(PCT_MUL);
    return p[32 +: PCT_W];
  endfunction

  logic [WINDOW_W-1:0]   tick_q, tick_d, tick_inc;
  logic [PULSE_BITS-1:0] pulse_q, pulse_d;
  logic [TEMP_W-1:0]     engine_q, engine_d, cabin_q, cabin_d;
  logic [PCT_W-1:0]      fuel_q, fuel_d, batt_q, batt_d;
  logic [DOOR_W-1:0]     door_q, door_d;
  logic [SEAT_W-1:0]     belt_q, belt_d;
  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [SETPOINT_W-1:0] sp_q, sp_d;
  logic                  ac_q, ac_d;
  logic                  accept, frame;
  logic [SAMPLE_W-1:0]   smp;
  logic [TEMP_W-1:0]     smp_temp;
  logic [PCT_W-1:0]      smp_pct;
  opcode_e               op;

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid;
  assign accept       = item_i.valid && push_ready_i;
  assign op           = opcode_e'(item_i.opcode);
  assign smp          = SAMPLE_W'(item_i.sample[SW-1:0]);
  assign smp_temp     = temp_of(smp);
  assign smp_pct      = pct_of(smp);
  assign tick_inc     = (tick_q != TICK_MAX) ? tick_q + 8'd1 : tick_q;

  always_comb begin
    tick_d   = tick_q;
    pulse_d  = pulse_q;
    engine_d = engine_q;
    cabin_d  = cabin_q;
    fuel_d   = fuel_q;
    batt_d   = batt_q;
    door_d   = door_q;
    belt_d   = belt_q;
    mode_d   = mode_q;
    frame    = 1'b0;

    unique case (op)
      OP_TICK: begin
        if (tick_inc >= cfg_i.window_ticks) begin
          frame   = 1'b1;
          tick_d  = '0;
          pulse_d = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      OP_PULSE: begin
        if (pulse_q != PULSE_MAX) begin
          pulse_d = pulse_q + 1'b1;
        end
      end
      OP_SAMPLE: begin
        unique case (channel_e'(item_i.channel))
          CH_ENGINE:  engine_d = smp_temp;
          CH_FUEL:    fuel_d   = smp_pct;
          CH_BATTERY: batt_d   = smp_pct;
          CH_CABIN:   cabin_d  = smp_temp;
        endcase
      end
      OP_SWITCH: begin
        door_d = item_i.door_switches;
        belt_d = item_i.seat_switches;
        mode_d = {item_i.manual_mode, item_i.auto_mode};
      end
      default: ;
    endcase
  end

  // Climate controller: runs after every item on the updated cabin temp and modes
  always_comb begin
    sp_d = sp_q;
    ac_d = ac_q;
    if (mode_d == '0) begin
      ac_d = 1'b0;
    end
    if (mode_d[0]) begin
      sp_d = (cfg_i.auto_setpoint > SETPOINT_MAX) ? SETPOINT_MAX : cfg_i.auto_setpoint;
      if (cabin_d > TEMP_W'(sp_d)) begin
        ac_d = 1'b1;
      end else if (cabin_d < TEMP_W'(cfg_i.auto_off_temp)) begin
        ac_d = 1'b0;
      end
    end
    if (mode_d[1]) begin
      if (op == OP_UP && sp_d < SETPOINT_MAX) begin
        sp_d = sp_d + 7'd1;
      end
      if (op == OP_DOWN && sp_d != '0) begin
        sp_d = sp_d - 7'd1;
      end
      if (cabin_d > TEMP_W'(sp_d)) begin
        ac_d = 1'b1;
      end else if ((10'(cabin_d) + 10'(cfg_i.manual_band)) <= 10'(sp_d)) begin
        ac_d = 1'b0;
      end
    end
  end

  always_comb begin
    push_info_o.is_frame    = frame;
    push_info_o.engine_temp = engine_q;
    push_info_o.fuel_pct    = fuel_q;
    push_info_o.batt_pct    = batt_q;
    push_info_o.door_ok     = (door_q == '1);
    push_info_o.belt_ok     = (belt_q == '1);
    push_info_o.ac_on       = ac_d;
    push_info_o.setpoint    = sp_d;
  end
  assign push_pulse_o = pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      pulse_q  <= '0;
      engine_q <= '0;
      cabin_q  <= '0;
      fuel_q   <= '0;
      batt_q   <= '0;
      door_q   <= '0;
      belt_q   <= '0;
      mode_q   <= '0;
      sp_q     <= SETPOINT_RESET;
      ac_q     <= 1'b0;
    end else if (accept) begin
      tick_q   <= tick_d;
      pulse_q  <= pulse_d;
      engine_q <= engine_d;
      cabin_q  <= cabin_d;
      fuel_q   <= fuel_d;
      batt_q   <= batt_d;
      door_q   <= door_d;
      belt_q   <= belt_d;
      mode_q   <= mode_d;
      sp_q     <= sp_d;
      ac_q     <= ac_d;
    end
  end

  a_setpoint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SETPOINT_MAX)
    else $error("setpoint left its range");

  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame |=> tick_q == '0 && pulse_q == '0)
    else $error("window counters not cleared after frame");

endmodule

`default_nettype wire

/* sv/dtf_back.sv */
// Back end: computes speed from the queued pulse count and serializes results,
// eight bytes for a frame and one result otherwise. Depends on dtf_pkg and dtf_out_if.
`default_nettype none

module dtf_back #(
  parameter int PULSE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [dtf_pkg::SCALE_W-1:0]   speed_scale_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  dtf_pkg::item_info_t           pop_info_i,
  input  logic [PULSE_BITS-1:0]         pop_pulse_i,
  dtf_out_if.source                     result_o
);

  import dtf_pkg::*;

  localparam int PROD_W = PULSE_BITS + SCALE_W;
  localparam int CMP_W  = (PROD_W > QUOT_IN_W + 1) ? PROD_W : QUOT_IN_W + 1;
  localparam int QUOT_W = QUOT_IN_W + 27;
  localparam logic [CMP_W-1:0] SAT_LIMIT = CMP_W'(SPEED_SAT_LIMIT);

  // product stage
  logic              p_valid_q;
  item_info_t        p_info_q;
  logic [PROD_W-1:0] p_prod_q;
  // speed stage, also the output register
  logic              s_valid_q;
  item_info_t        s_info_q;
  logic [SPEED_W-1:0] s_speed_q;
  logic [INDEX_W-1:0] idx_q;

  logic               p_ready, s_ready, fire, last;
  logic [CMP_W-1:0]   prod_ext;
  logic [QUOT_W-1:0]  quot;
  logic [SPEED_W-1:0] speed;
  logic [BYTE_W-1:0]  byte_sel;

  assign last        = !s_info_q.is_frame || (idx_q == FB_BATTERY);
  assign fire        = s_valid_q && result_o.ready;
  assign s_ready     = !s_valid_q || (fire && last);
  assign p_ready     = !p_valid_q || s_ready;
  assign pop_ready_o = p_ready;

  assign prod_ext = CMP_W'(p_prod_q);
  assign quot     = QUOT_W'(prod_ext[QUOT_IN_W-1:0]) * QUOT_W'(SPEED_RECIP);
  assign speed    = (prod_ext >= SAT_LIMIT) ? '1 : quot[SPEED_SHIFT +: SPEED_W];

  always_comb begin
    unique case (frame_byte_e'(idx_q))
      FB_ENGINE_HI: byte_sel = BYTE_W'(s_info_q.engine_temp[TEMP_W-1:BYTE_W]);
      FB_ENGINE_LO: byte_sel = s_info_q.engine_temp[BYTE_W-1:0];
      FB_FUEL:      byte_sel = BYTE_W'(s_info_q.fuel_pct);
      FB_SPEED_HI:  byte_sel = s_speed_q[SPEED_W-1:BYTE_W];
      FB_SPEED_LO:  byte_sel = s_speed_q[BYTE_W-1:0];
      FB_DOOR:      byte_sel = BYTE_W'(s_info_q.door_ok);
      FB_BELT:      byte_sel = BYTE_W'(s_info_q.belt_ok);
      FB_BATTERY:   byte_sel = BYTE_W'(s_info_q.batt_pct);
    endcase
  end

  assign result_o.valid            = s_valid_q;
  assign result_o.is_frame         = s_info_q.is_frame;
  assign result_o.frame_byte       = s_info_q.is_frame ? byte_sel : '0;
  assign result_o.byte_index       = s_info_q.is_frame ? idx_q : '0;
  assign result_o.last             = last;
  assign result_o.ac_on            = s_info_q.ac_on;
  assign result_o.current_setpoint = s_info_q.setpoint;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (p_ready) begin
        p_valid_q <= pop_valid_i;
      end
      if (s_ready) begin
        s_valid_q <= p_valid_q;
      end
      if (fire) begin
        idx_q <= last ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && pop_valid_i) begin
      p_info_q <= pop_info_i;
      p_prod_q <= PROD_W'(pop_pulse_i) * PROD_W'(speed_scale_i);
    end
    if (s_ready && p_valid_q) begin
      s_info_q  <= p_info_q;
      s_speed_q <= speed;
    end
  end

  a_single_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && !s_info_q.is_frame |-> idx_q == '0)
    else $error("byte counter moved on a non-frame transaction");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !last |=> idx_q == $past(idx_q) + 1'b1)
    else $error("byte counter skipped a position");

  a_prod_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !s_ready |=> p_valid_q && $stable(p_prod_q))
    else $error("product stage lost data under stall");

endmodule

`default_nettype wire

/* sv/dashboard_telemetry_framer_top.sv */
// Dashboard telemetry framer: APB register file plus front end, queue and back end.
// Depends on dtf_pkg, dtf_if, dtf_fifo, dtf_front and dtf_back.
// Usage:
//   item_i carries one event per transaction (tick, wheel pulse, converter sample,
//   switch update, setpoint up/down). result_o returns one result per item, or
//   eight frame bytes (byte_index 0..7, last on byte 7) when a tick closes the
//   speed window. Every result also reports the AC drive state and setpoint.
//   The APB port holds window_ticks, speed_scale, auto_setpoint, auto_off_temp and
//   manual_band at byte addresses 0, 4, 8, 12, 16; write them only while idle.
// Timing:
//   One item is accepted per cycle while the queue has room. Its first result passes
//   through the queue, the product stage and the speed/output stage, in that order.
//   A frame holds the output stage while its eight bytes go out; the product
//   stage and the 4-entry queue absorb up to five more items meanwhile.
// Reset:
//   rst_ni clears counters, samples, switch levels, the AC state and the queue,
//   loads setpoint 25 and the register defaults. No clearing pass is needed.
// Stall:
//   A low result_o.ready holds the current result; items keep entering until the
//   queue fills, then item_i.ready drops.
`default_nettype none

module dashboard_telemetry_framer_top #(
  parameter int PULSE_BITS  = 16,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  dtf_in_if.sink                          item_i,
  dtf_out_if.source                       result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [dtf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [dtf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import dtf_pkg::*;

  localparam int Q_W = $bits(item_info_t) + PULSE_BITS;

  cfg_t                  cfg_q;
  reg_idx_e              reg_idx;
  logic                  cfg_we;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  item_info_t            push_info, pop_info;
  logic [PULSE_BITS-1:0] push_pulse, pop_pulse;
  logic [Q_W-1:0]        pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks  <= WINDOW_RESET;
      cfg_q.speed_scale   <= SCALE_RESET;
      cfg_q.auto_setpoint <= AUTO_SP_RESET;
      cfg_q.auto_off_temp <= AUTO_OFF_RESET;
      cfg_q.manual_band   <= BAND_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_WINDOW:   cfg_q.window_ticks  <= pwdata[WINDOW_W-1:0];
        REG_SCALE:    cfg_q.speed_scale   <= pwdata[SCALE_W-1:0];
        REG_AUTO_SP:  cfg_q.auto_setpoint <= pwdata[SETPOINT_W-1:0];
        REG_AUTO_OFF: cfg_q.auto_off_temp <= pwdata[SETPOINT_W-1:0];
        REG_BAND:     cfg_q.manual_band   <= pwdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW:   prdata = APB_DATA_W'(cfg_q.window_ticks);
      REG_SCALE:    prdata = APB_DATA_W'(cfg_q.speed_scale);
      REG_AUTO_SP:  prdata = APB_DATA_W'(cfg_q.auto_setpoint);
      REG_AUTO_OFF: prdata = APB_DATA_W'(cfg_q.auto_off_temp);
      REG_BAND:     prdata = APB_DATA_W'(cfg_q.manual_band);
      default:      prdata = '0;
    endcase
  end

  dtf_front #(
    .PULSE_BITS  (PULSE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_info_o  (push_info),
    .push_pulse_o (push_pulse)
  );

  dtf_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_pulse, push_info}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign pop_info  = item_info_t'(pop_data[$bits(item_info_t)-1:0]);
  assign pop_pulse = pop_data[Q_W-1 -: PULSE_BITS];

  dtf_back #(
    .PULSE_BITS (PULSE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .speed_scale_i (cfg_q.speed_scale),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_info_i    (pop_info),
    .pop_pulse_i   (pop_pulse),
    .result_o      (result_o)
  );

endmodule

`default_nettype wire
